/* src/ecdma_pkg.sv */
// ----------------------------------------------------------------------------
// ecdma_pkg: shared types and constants of the DMA / HDMA controller
// Command codes, engine phases, register indexes and the unit pattern tables.
// ----------------------------------------------------------------------------
package ecdma_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam logic [7:0] CHAN_BITS = 8'((1 << NUM_CHANNELS) - 1);

  localparam logic [23:0] B_BASE = 24'h002100;
  localparam logic [7:0]  LINE_COUNT_MASK = 8'h7F;
  localparam int MODE_DIR_BIT = 7;
  localparam int MODE_IND_BIT = 6;
  localparam int MODE_DEC_BIT = 4;
  localparam int MODE_FIX_BIT = 3;
  localparam int LINE_REPEAT_BIT = 7;
  localparam logic [16:0] FULL_COUNT = 17'h10000;
  localparam logic [7:0]  UNUSED_READ = 8'hFF;

  typedef enum logic [2:0] {
    CMD_REG_WRITE = 3'd0,
    CMD_REG_READ  = 3'd1,
    CMD_DMA_START = 3'd2,
    CMD_HDMA_EN   = 3'd3,
    CMD_FRAME     = 3'd4,
    CMD_HBLANK    = 3'd5,
    CMD_STEP      = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    REG_MODE     = 4'd0,
    REG_B_ADDR   = 4'd1,
    REG_A_LO     = 4'd2,
    REG_A_HI     = 4'd3,
    REG_A_BANK   = 4'd4,
    REG_CNT_LO   = 4'd5,
    REG_CNT_HI   = 4'd6,
    REG_IND_BANK = 4'd7,
    REG_TBL_LO   = 4'd8,
    REG_TBL_HI   = 4'd9,
    REG_LINE     = 4'd10
  } reg_idx_t;

  typedef enum logic [12:0] {
    P_IDLE     = 13'b0000000000001,
    P_DMA_RD   = 13'b0000000000010,
    P_DMA_WR   = 13'b0000000000100,
    P_HI_LINE  = 13'b0000000001000,
    P_HI_LATCH = 13'b0000000010000,
    P_HI_INDL  = 13'b0000000100000,
    P_HI_INDH  = 13'b0000001000000,
    P_HT_LINE  = 13'b0000010000000,
    P_HT_LATCH = 13'b0000100000000,
    P_HT_INDL  = 13'b0001000000000,
    P_HT_INDH  = 13'b0010000000000,
    P_HT_RD    = 13'b0100000000000,
    P_HT_WR    = 13'b1000000000000
  } phase_t;

  // Bytes moved per transfer unit, by mode pattern.
  function automatic logic [2:0] unit_size(input logic [2:0] pat);
    logic [2:0] s;
    unique case (pat)
      3'd0:                s = 3'd1;
      3'd1, 3'd2, 3'd6:    s = 3'd2;
      default:             s = 3'd4;
    endcase
    return s;
  endfunction

  // B address offset of each byte within a unit.
  function automatic logic [1:0] unit_off(input logic [2:0] pat, input logic [1:0] idx);
    logic [1:0] o;
    unique case (pat)
      3'd1, 3'd5: o = {1'b0, idx[0]};
      3'd3, 3'd7: o = {1'b0, idx[1]};
      3'd4:       o = idx;
      default:    o = 2'd0;
    endcase
    return o;
  endfunction

endpackage

/* src/eight_channel_dma_hdma_controller_unit.sv */
// ----------------------------------------------------------------------------
// eight_channel_dma_hdma_controller_unit: eight-channel DMA and HDMA engine
// Register file, general DMA sequencer and per-scanline table engine.
// ----------------------------------------------------------------------------
// Each accepted item is one command: a register write or read, a DMA start
// mask, an HDMA enable mask, a frame start, an h-blank or a bus step. Every
// item yields exactly one result item in the cycle after acceptance, and a new
// item can be accepted in every cycle; the result sits in an output register
// and the input stays ready while that register is empty or being drained.
// The whole update of an item, including the scan over the eight channels at
// h-blank, is a single pass of logic from the state registers into the state
// and result registers. A bus step issues at most one bus read or write; data
// read on one step is returned with the next. While a sequence runs (busy_res
// high), commands other than register reads and bus steps are refused and
// leave the state untouched.
module eight_channel_dma_hdma_controller_unit
  import ecdma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [6:0]  reg_addr,
  input  logic [7:0]  wdata,
  input  logic [7:0]  bus_rdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        bus_valid,
  output logic        bus_write,
  output logic [23:0] bus_addr,
  output logic [7:0]  bus_wdata,
  output logic        busy_res,
  output logic        irq_lock,
  output logic        refused
);

  // Channel register file.
  logic [7:0]  mode       [NUM_CHANNELS];
  logic [7:0]  b_addr     [NUM_CHANNELS];
  logic [15:0] a_addr     [NUM_CHANNELS];
  logic [7:0]  a_bank     [NUM_CHANNELS];
  logic [15:0] count      [NUM_CHANNELS];
  logic [7:0]  ind_bank   [NUM_CHANNELS];
  logic [15:0] table_addr [NUM_CHANNELS];
  logic [7:0]  line_ctrl  [NUM_CHANNELS];
  logic [7:0]  line_cnt   [NUM_CHANNELS];
  logic        do_xfer    [NUM_CHANNELS];
  logic        term       [NUM_CHANNELS];

  logic [7:0]  mode_next       [NUM_CHANNELS];
  logic [7:0]  b_addr_next     [NUM_CHANNELS];
  logic [15:0] a_addr_next     [NUM_CHANNELS];
  logic [7:0]  a_bank_next     [NUM_CHANNELS];
  logic [15:0] count_next      [NUM_CHANNELS];
  logic [7:0]  ind_bank_next   [NUM_CHANNELS];
  logic [15:0] table_addr_next [NUM_CHANNELS];
  logic [7:0]  line_ctrl_next  [NUM_CHANNELS];
  logic [7:0]  line_cnt_next   [NUM_CHANNELS];
  logic        do_xfer_next    [NUM_CHANNELS];
  logic        term_next       [NUM_CHANNELS];

  // Engine state.
  logic [7:0]  hdma_en, hdma_en_next;
  logic [7:0]  dma_pend, dma_pend_next;
  logic [7:0]  hdma_pend, hdma_pend_next;
  phase_t      phase, phase_next;
  logic [2:0]  active, active_next;
  logic [1:0]  unit_idx, unit_idx_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [23:0] work_addr, work_addr_next;

  // Result of the item being accepted.
  logic [7:0]  r_rdata, r_wdata;
  logic        r_valid, r_write, r_irq, r_refused;
  logic [23:0] r_addr;

  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Source address of one HDMA copy: indirect address or the table pointer.
  function automatic logic [23:0] copy_base(input logic [7:0] m, input logic [7:0] ib,
                                            input logic [15:0] cnt, input logic [7:0] ab,
                                            input logic [15:0] tbl);
    return m[MODE_IND_BIT] ? {ib, cnt} : {ab, tbl};
  endfunction

  always_comb begin
    logic [2:0]  c;
    logic [7:0]  m;
    logic [3:0]  ch_sel;
    logic [15:0] lo;
    logic        call_dma, call_hinit, call_hxfer, from_step, found, xfer_path;
    logic        busy;
    logic [7:0]  d;

    mode_next       = mode;
    b_addr_next     = b_addr;
    a_addr_next     = a_addr;
    a_bank_next     = a_bank;
    count_next      = count;
    ind_bank_next   = ind_bank;
    table_addr_next = table_addr;
    line_ctrl_next  = line_ctrl;
    line_cnt_next   = line_cnt;
    do_xfer_next    = do_xfer;
    term_next       = term;
    hdma_en_next    = hdma_en;
    dma_pend_next   = dma_pend;
    hdma_pend_next  = hdma_pend;
    phase_next      = phase;
    active_next     = active;
    unit_idx_next   = unit_idx;
    bytes_left_next = bytes_left;
    work_addr_next  = work_addr;

    r_rdata = '0; r_valid = 1'b0; r_write = 1'b0; r_addr = '0; r_wdata = '0;
    r_irq = 1'b0; r_refused = 1'b0;
    call_dma = 1'b0; call_hinit = 1'b0; call_hxfer = 1'b0; from_step = 1'b0;
    found = 1'b0; xfer_path = 1'b0;
    c = active;
    m = mode[active];
    d = bus_rdata;
    lo = '0;
    ch_sel = {1'b0, reg_addr[6:4]};
    busy = (phase != P_IDLE);

    if (busy && (cmd == CMD_REG_WRITE || cmd == CMD_DMA_START || cmd == CMD_HDMA_EN ||
                 cmd == CMD_FRAME || cmd == CMD_HBLANK)) begin
      r_refused = 1'b1;
    end else begin
      priority case (cmd)
        CMD_REG_WRITE: begin
          if (ch_sel < 4'(NUM_CHANNELS)) begin
            unique case (reg_addr[3:0])
              REG_MODE:     mode_next[reg_addr[6:4]] = wdata;
              REG_B_ADDR:   b_addr_next[reg_addr[6:4]] = wdata;
              REG_A_LO:     a_addr_next[reg_addr[6:4]][7:0] = wdata;
              REG_A_HI:     a_addr_next[reg_addr[6:4]][15:8] = wdata;
              REG_A_BANK:   a_bank_next[reg_addr[6:4]] = wdata;
              REG_CNT_LO:   count_next[reg_addr[6:4]][7:0] = wdata;
              REG_CNT_HI:   count_next[reg_addr[6:4]][15:8] = wdata;
              REG_IND_BANK: ind_bank_next[reg_addr[6:4]] = wdata;
              REG_TBL_LO:   table_addr_next[reg_addr[6:4]][7:0] = wdata;
              REG_TBL_HI:   table_addr_next[reg_addr[6:4]][15:8] = wdata;
              REG_LINE:     line_ctrl_next[reg_addr[6:4]] = wdata;
              default: ;
            endcase
          end
        end
        CMD_REG_READ: begin
          r_rdata = UNUSED_READ;
          if (ch_sel < 4'(NUM_CHANNELS)) begin
            unique case (reg_addr[3:0])
              REG_MODE:     r_rdata = mode[reg_addr[6:4]];
              REG_B_ADDR:   r_rdata = b_addr[reg_addr[6:4]];
              REG_A_LO:     r_rdata = a_addr[reg_addr[6:4]][7:0];
              REG_A_HI:     r_rdata = a_addr[reg_addr[6:4]][15:8];
              REG_A_BANK:   r_rdata = a_bank[reg_addr[6:4]];
              REG_CNT_LO:   r_rdata = count[reg_addr[6:4]][7:0];
              REG_CNT_HI:   r_rdata = count[reg_addr[6:4]][15:8];
              REG_IND_BANK: r_rdata = ind_bank[reg_addr[6:4]];
              REG_TBL_LO:   r_rdata = table_addr[reg_addr[6:4]][7:0];
              REG_TBL_HI:   r_rdata = table_addr[reg_addr[6:4]][15:8];
              REG_LINE:     r_rdata = line_ctrl[reg_addr[6:4]];
              default:      r_rdata = UNUSED_READ;
            endcase
          end
        end
        CMD_DMA_START: begin
          dma_pend_next = wdata & CHAN_BITS;
          call_dma = (dma_pend_next != '0);
        end
        CMD_HDMA_EN: begin
          hdma_pend_next = wdata & ~hdma_en & CHAN_BITS;
          hdma_en_next   = wdata & CHAN_BITS;
          call_hinit = 1'b1;
        end
        CMD_FRAME: begin
          hdma_pend_next = hdma_en;
          call_hinit = 1'b1;
        end
        CMD_HBLANK: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            hdma_pend_next[i] = hdma_en[i] && !term[i];
          end
          call_hxfer = 1'b1;
        end
        CMD_STEP: begin
          unique case (phase)
            P_IDLE: ;
            P_DMA_RD: begin
              r_valid = 1'b1;
              r_addr  = m[MODE_DIR_BIT] ?
                        (B_BASE | 24'(8'(b_addr[c] + 8'(unit_off(m[2:0], unit_idx))))) :
                        work_addr;
              phase_next = P_DMA_WR;
            end
            P_DMA_WR: begin
              r_valid = 1'b1;
              r_write = 1'b1;
              r_wdata = d;
              r_addr  = m[MODE_DIR_BIT] ? work_addr :
                        (B_BASE | 24'(8'(b_addr[c] + 8'(unit_off(m[2:0], unit_idx)))));
              if (!m[MODE_FIX_BIT]) begin
                lo = m[MODE_DEC_BIT] ? work_addr[15:0] - 16'd1 : work_addr[15:0] + 16'd1;
                work_addr_next = {work_addr[23:16], lo};
              end
              unit_idx_next   = (unit_idx + 2'd1) & 2'(unit_size(m[2:0]) - 3'd1);
              bytes_left_next = bytes_left - 17'd1;
              if (bytes_left_next == '0) begin
                a_addr_next[c] = work_addr_next[15:0];
                count_next[c]  = '0;
                call_dma  = 1'b1;
                from_step = 1'b1;
              end else begin
                phase_next = P_DMA_RD;
              end
            end
            P_HI_LINE, P_HT_LINE: begin
              r_valid = 1'b1;
              r_addr  = {a_bank[c], table_addr[c]};
              table_addr_next[c] = table_addr[c] + 16'd1;
              phase_next = (phase == P_HI_LINE) ? P_HI_LATCH : P_HT_LATCH;
            end
            P_HI_LATCH, P_HT_LATCH: begin
              xfer_path = (phase == P_HT_LATCH);
              line_ctrl_next[c] = d;
              line_cnt_next[c]  = d & LINE_COUNT_MASK;
              if (d == '0) begin
                term_next[c] = 1'b1;
                call_hxfer = xfer_path;
                call_hinit = !xfer_path;
              end else begin
                do_xfer_next[c] = 1'b1;
                if (m[MODE_IND_BIT]) begin
                  r_valid = 1'b1;
                  r_addr  = {a_bank[c], table_addr[c]};
                  table_addr_next[c] = table_addr[c] + 16'd1;
                  phase_next = xfer_path ? P_HT_INDL : P_HI_INDL;
                end else if (!xfer_path) begin
                  call_hinit = 1'b1;
                end else begin
                  // Start the copy of this line's unit right away.
                  work_addr_next  = copy_base(m, ind_bank[c], count[c], a_bank[c],
                                              table_addr[c]);
                  unit_idx_next   = '0;
                  bytes_left_next = 17'(unit_size(m[2:0]));
                  phase_next      = P_HT_RD;
                end
              end
            end
            P_HI_INDL, P_HT_INDL: begin
              count_next[c] = {8'd0, d};
              r_valid = 1'b1;
              r_addr  = {a_bank[c], table_addr[c]};
              table_addr_next[c] = table_addr[c] + 16'd1;
              phase_next = (phase == P_HI_INDL) ? P_HI_INDH : P_HT_INDH;
            end
            P_HI_INDH, P_HT_INDH: begin
              count_next[c] = count[c] | {d, 8'd0};
              if (phase == P_HI_INDH) begin
                call_hinit = 1'b1;
              end else if (do_xfer[c]) begin
                work_addr_next  = copy_base(m, ind_bank[c], count_next[c], a_bank[c],
                                            table_addr[c]);
                unit_idx_next   = '0;
                bytes_left_next = 17'(unit_size(m[2:0]));
                phase_next      = P_HT_RD;
              end else begin
                line_cnt_next[c] = line_cnt[c] - 8'd1;
                do_xfer_next[c]  = (line_cnt_next[c] == '0) || line_ctrl[c][LINE_REPEAT_BIT];
                call_hxfer = 1'b1;
              end
            end
            P_HT_RD: begin
              r_valid = 1'b1;
              r_addr  = work_addr;
              phase_next = P_HT_WR;
            end
            P_HT_WR: begin
              r_valid = 1'b1;
              r_write = 1'b1;
              r_wdata = d;
              r_addr  = B_BASE | 24'(8'(b_addr[c] + 8'(unit_off(m[2:0], unit_idx))));
              work_addr_next  = {work_addr[23:16], work_addr[15:0] + 16'd1};
              unit_idx_next   = (unit_idx + 2'd1) & 2'(unit_size(m[2:0]) - 3'd1);
              bytes_left_next = bytes_left - 17'd1;
              if (bytes_left_next == '0) begin
                if (m[MODE_IND_BIT]) count_next[c] = work_addr_next[15:0];
                else table_addr_next[c] = work_addr_next[15:0];
                line_cnt_next[c] = line_cnt[c] - 8'd1;
                do_xfer_next[c]  = (line_cnt_next[c] == '0) || line_ctrl[c][LINE_REPEAT_BIT];
                call_hxfer = 1'b1;
              end else begin
                phase_next = P_HT_RD;
              end
            end
            default: phase_next = P_IDLE;
          endcase
        end
        default: ;
      endcase
    end

    // Start the lowest pending general DMA channel.
    if (call_dma) begin
      phase_next = P_IDLE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (!found && dma_pend_next[i]) begin
          found = 1'b1;
          dma_pend_next[i] = 1'b0;
          active_next      = 3'(i);
          work_addr_next   = {a_bank_next[i], a_addr_next[i]};
          bytes_left_next  = (count_next[i] != '0) ? {1'b0, count_next[i]} : FULL_COUNT;
          unit_idx_next    = '0;
          phase_next       = P_DMA_RD;
        end
      end
      r_irq = from_step && !found;
    end

    // Load the first table entry of the lowest pending HDMA channel.
    if (call_hinit) begin
      phase_next = P_IDLE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (!found && hdma_pend_next[i]) begin
          found = 1'b1;
          hdma_pend_next[i]  = 1'b0;
          active_next        = 3'(i);
          table_addr_next[i] = a_addr_next[i];
          term_next[i]       = 1'b0;
          do_xfer_next[i]    = 1'b0;
          phase_next         = P_HI_LINE;
        end
      end
    end

    // Scanline scan: channels with nothing to do this line just count down;
    // the first one that needs a new entry or a copy takes over the engine.
    if (call_hxfer) begin
      phase_next = P_IDLE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (!found && hdma_pend_next[i]) begin
          hdma_pend_next[i] = 1'b0;
          active_next       = 3'(i);
          if (line_cnt_next[i] == '0) begin
            found = 1'b1;
            phase_next = P_HT_LINE;
          end else if (do_xfer_next[i]) begin
            found = 1'b1;
            work_addr_next  = copy_base(mode_next[i], ind_bank_next[i], count_next[i],
                                        a_bank_next[i], table_addr_next[i]);
            unit_idx_next   = '0;
            bytes_left_next = 17'(unit_size(mode_next[i][2:0]));
            phase_next      = P_HT_RD;
          end else begin
            line_cnt_next[i] = line_cnt_next[i] - 8'd1;
            do_xfer_next[i]  = (line_cnt_next[i] == '0) ||
                               line_ctrl_next[i][LINE_REPEAT_BIT];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mode[i]       <= '1;
        b_addr[i]     <= '1;
        a_addr[i]     <= '1;
        a_bank[i]     <= '1;
        count[i]      <= '1;
        ind_bank[i]   <= '1;
        table_addr[i] <= '1;
        line_ctrl[i]  <= '1;
        line_cnt[i]   <= '0;
        do_xfer[i]    <= 1'b0;
        term[i]       <= 1'b0;
      end
      hdma_en    <= '0;
      dma_pend   <= '0;
      hdma_pend  <= '0;
      phase      <= P_IDLE;
      active     <= '0;
      unit_idx   <= '0;
      bytes_left <= '0;
      work_addr  <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      b_addr     <= b_addr_next;
      a_addr     <= a_addr_next;
      a_bank     <= a_bank_next;
      count      <= count_next;
      ind_bank   <= ind_bank_next;
      table_addr <= table_addr_next;
      line_ctrl  <= line_ctrl_next;
      line_cnt   <= line_cnt_next;
      do_xfer    <= do_xfer_next;
      term       <= term_next;
      hdma_en    <= hdma_en_next;
      dma_pend   <= dma_pend_next;
      hdma_pend  <= hdma_pend_next;
      phase      <= phase_next;
      active     <= active_next;
      unit_idx   <= unit_idx_next;
      bytes_left <= bytes_left_next;
      work_addr  <= work_addr_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= r_rdata;
      bus_valid <= r_valid;
      bus_write <= r_write;
      bus_addr  <= r_addr;
      bus_wdata <= r_wdata;
      busy_res  <= (phase_next != P_IDLE);
      irq_lock  <= r_irq;
      refused   <= r_refused;
    end
  end

`ifndef SYNTHESIS
  a_busy_matches_phase: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy_res == (phase != P_IDLE))
    else $error("busy flag disagrees with engine phase");
  a_irq_means_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_lock |-> !busy_res)
    else $error("DMA completion reported while engine still busy");
  a_write_has_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_write |-> bus_valid)
    else $error("bus write flagged without a bus operation");
  a_refused_no_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && refused |-> !bus_valid && busy_res)
    else $error("refused item carried a bus operation or engine idle");
`endif

endmodule
